/* rtl/assert_macros.svh */
// Assertion helpers for the checker file.
// Every macro samples on the rising edge of clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while reset is low.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/ecv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ecv_pkg;

   // Curve selectors
   localparam logic [3:0] KIND_LINEAR      = 4'd0;
   localparam logic [3:0] KIND_QUAD_IN     = 4'd1;
   localparam logic [3:0] KIND_QUAD_OUT    = 4'd2;
   localparam logic [3:0] KIND_QUAD_INOUT  = 4'd3;
   localparam logic [3:0] KIND_CUBIC_IN    = 4'd4;
   localparam logic [3:0] KIND_CUBIC_OUT   = 4'd5;
   localparam logic [3:0] KIND_CUBIC_INOUT = 4'd6;
   localparam logic [3:0] KIND_BACK        = 4'd7;
   localparam logic [3:0] KIND_BOUNCE      = 4'd8;
   localparam logic [3:0] KIND_ELASTIC     = 4'd9;
   localparam logic [3:0] KIND_STEP        = 4'd10;

   localparam logic [9:0]  UNIT       = 10'd256;
   localparam logic [16:0] BACK_S     = 17'd435;
   localparam logic [19:0] BACK_S1    = 20'd691;   // s + 1 in 8.8
   localparam logic [10:0] BOUNCE_K   = 11'd1936;
   localparam logic [7:0]  BOUNCE_E1  = 8'd93;
   localparam logic [7:0]  BOUNCE_E2  = 8'd186;
   localparam logic [7:0]  BOUNCE_E3  = 8'd233;
   localparam logic [8:0]  BOUNCE_C2  = 9'd140;
   localparam logic [8:0]  BOUNCE_C3  = 9'd209;
   localparam logic [8:0]  BOUNCE_C4  = 9'd244;
   localparam logic [8:0]  BOUNCE_B2  = 9'd192;
   localparam logic [8:0]  BOUNCE_B3  = 9'd240;
   localparam logic [8:0]  BOUNCE_B4  = 9'd252;

   typedef logic signed [9:0] eased_type;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] t;
      logic       lo;
      logic       hi;
   } s1_type;

   typedef struct packed {
      logic [3:0]         kind;
      logic [7:0]         t;
      logic               lo;
      logic               hi;
      logic               upper;
      logic [7:0]         m;
      logic [15:0]        p1;
      logic [8:0]         base;
      logic [9:0]         el_a;
      logic signed [13:0] el_p;
   } s2_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic        lo;
      logic        hi;
      logic        upper;
      logic [9:0]  early;
      logic [26:0] p2;
      logic [8:0]  bk2;
      logic [8:0]  base;
   } s3_type;

   // Elastic-out sample points, 17 entries
   function automatic logic [9:0] elastic_pt(input logic [4:0] idx);
      logic [9:0] v;
      case (idx)
         5'd0:    v = 10'd0;
         5'd1:    v = 10'd213;
         5'd2:    v = 10'd349;
         5'd3:    v = 10'd305;
         5'd4:    v = 10'd233;
         5'd5:    v = 10'd228;
         5'd6:    v = 10'd256;
         5'd7:    v = 10'd268;
         5'd8:    v = 10'd260;
         5'd9:    v = 10'd252;
         5'd10:   v = 10'd253;
         5'd11:   v = 10'd257;
         5'd12:   v = 10'd257;
         5'd13:   v = 10'd256;
         5'd14:   v = 10'd255;
         5'd15:   v = 10'd256;
         5'd16:   v = 10'd256;
         default: v = 10'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

/* rtl/ecv_square.sv */
`timescale 1ns / 1ps
`default_nettype none

module ecv_square (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   input  wire logic           advance,
   input  wire ecv_pkg::s1_type s1,
   output logic                out_valid,
   output ecv_pkg::s2_type     s2
);
   import ecv_pkg::*;

   logic               valid_ff;
   s2_type             s2_ff;
   s2_type             s2_in;
   logic [8:0]         rem;
   logic [7:0]         inv;
   logic signed [8:0]  off;
   logic [7:0]         mag;
   logic [8:0]         base;
   logic [7:0]         m;
   logic [4:0]         idx;
   logic [9:0]         pa;
   logic [9:0]         pb;
   logic [9:0]         d;
   logic signed [13:0] d_ext;
   logic signed [13:0] f_ext;

   always_comb begin
      rem = 9'd256 - {1'b0, s1.t};
      inv = rem[7:0];

      // pick the bounce segment
      if (s1.t < BOUNCE_E1) begin
         off  = $signed({1'b0, s1.t});
         base = 9'd0;
      end else if (s1.t < BOUNCE_E2) begin
         off  = $signed({1'b0, s1.t} - BOUNCE_C2);
         base = BOUNCE_B2;
      end else if (s1.t < BOUNCE_E3) begin
         off  = $signed({1'b0, s1.t} - BOUNCE_C3);
         base = BOUNCE_B3;
      end else begin
         off  = $signed({1'b0, s1.t} - BOUNCE_C4);
         base = BOUNCE_B4;
      end
      mag = off[8] ? 8'(-off) : off[7:0];

      unique case (s1.kind) inside
         KIND_QUAD_OUT, KIND_CUBIC_OUT, KIND_BACK: m = inv;
         KIND_QUAD_INOUT, KIND_CUBIC_INOUT:        m = s1.t[7] ? inv : s1.t;
         KIND_BOUNCE:                              m = mag;
         default:                                  m = s1.t;
      endcase

      // elastic: fetch segment end points, scale slope by fraction
      idx   = {1'b0, s1.t[7:4]};
      pa    = elastic_pt(idx);
      pb    = elastic_pt(idx + 5'd1);
      d     = pb - pa;
      d_ext = $signed({{4{d[9]}}, d});
      f_ext = $signed({10'd0, s1.t[3:0]});

      s2_in.kind  = s1.kind;
      s2_in.t     = s1.t;
      s2_in.lo    = s1.lo;
      s2_in.hi    = s1.hi;
      s2_in.upper = s1.t[7];
      s2_in.m     = m;
      s2_in.p1    = {8'd0, m} * {8'd0, m};
      s2_in.base  = base;
      s2_in.el_a  = pa;
      s2_in.el_p  = d_ext * f_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid = valid_ff;
   assign s2        = s2_ff;

endmodule

`default_nettype wire

/* rtl/ecv_product.sv */
`timescale 1ns / 1ps
`default_nettype none

module ecv_product (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   input  wire logic           advance,
   input  wire ecv_pkg::s2_type s2,
   output logic                out_valid,
   output ecv_pkg::s3_type     s3
);
   import ecv_pkg::*;

   logic               valid_ff;
   s3_type             s3_ff;
   s3_type             s3_in;
   logic [15:0]        x;
   logic [10:0]        y;
   logic [16:0]        bk_full;
   logic [9:0]         sq8;
   logic [9:0]         sq7;
   logic signed [13:0] el_r;
   logic [9:0]         early;

   always_comb begin
      unique case (s2.kind) inside
         KIND_CUBIC_IN, KIND_CUBIC_OUT, KIND_BACK: begin
            x = {8'd0, s2.p1[15:8]};
            y = {3'd0, s2.m};
         end
         KIND_BOUNCE: begin
            x = s2.p1;
            y = BOUNCE_K;
         end
         default: begin
            x = s2.p1;
            y = {3'd0, s2.m};
         end
      endcase

      bk_full = {9'd0, s2.p1[15:8]} * BACK_S;

      sq8 = {2'd0, s2.p1[15:8]};
      sq7 = {1'd0, s2.p1[15:7]};

      // truncate toward zero when dividing by 16
      if (s2.el_p < 0) begin
         el_r = (s2.el_p + 14'sd15) >>> 4;
      end else begin
         el_r = s2.el_p >>> 4;
      end

      unique case (s2.kind)
         KIND_QUAD_IN:    early = sq8;
         KIND_QUAD_OUT:   early = UNIT - sq8;
         KIND_QUAD_INOUT: early = s2.upper ? (UNIT - sq7) : sq7;
         KIND_ELASTIC:    early = s2.el_a + el_r[9:0];
         KIND_STEP:       early = 10'd0;
         default:         early = {2'd0, s2.t};
      endcase

      s3_in.kind  = s2.kind;
      s3_in.lo    = s2.lo;
      s3_in.hi    = s2.hi;
      s3_in.upper = s2.upper;
      s3_in.early = early;
      s3_in.p2    = {11'd0, x} * {16'd0, y};
      s3_in.bk2   = bk_full[16:8];
      s3_in.base  = s2.base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = valid_ff;
   assign s3        = s3_ff;

endmodule

`default_nettype wire

/* rtl/ecv_finish.sv */
`timescale 1ns / 1ps
`default_nettype none

module ecv_finish (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   input  wire logic           advance,
   input  wire ecv_pkg::s3_type s3,
   output logic                out_valid,
   output ecv_pkg::eased_type  eased
);
   import ecv_pkg::*;

   logic               valid_ff;
   eased_type          eased_ff;
   eased_type          eased_in;
   logic [9:0]         c8;
   logic [9:0]         c14;
   logic [15:0]        ceil_sum;
   logic [7:0]         ceil_q;
   logic signed [19:0] bk_prod;
   logic signed [19:0] bk_t1;
   logic [11:0]        bk_sum;
   logic [8:0]         bv;
   logic [9:0]         bounce;
   logic [9:0]         curve;

   always_comb begin
      c8  = {2'd0, s3.p2[15:8]};
      c14 = {1'd0, s3.p2[22:14]};

      // back-out: u3 = -ceil(u2*|u| / 256), then floor-scale by s+1
      ceil_sum = s3.p2[15:0] + 16'd255;
      ceil_q   = ceil_sum[15:8];
      bk_prod  = -($signed(BACK_S1) * $signed({12'd0, ceil_q}));
      bk_t1    = bk_prod >>> 8;
      bk_sum   = 12'd256 + bk_t1[11:0] + {3'd0, s3.bk2};

      // bounce: clamp the top of each arc at one
      bv     = {1'b0, s3.p2[23:16]} + s3.base;
      bounce = (bv > 9'd256) ? UNIT : {1'b0, bv};

      unique case (s3.kind)
         KIND_CUBIC_IN:    curve = c8;
         KIND_CUBIC_OUT:   curve = UNIT - c8;
         KIND_CUBIC_INOUT: curve = s3.upper ? (UNIT - c14) : c14;
         KIND_BACK:        curve = bk_sum[9:0];
         KIND_BOUNCE:      curve = bounce;
         default:          curve = s3.early;
      endcase

      if (s3.lo) begin
         eased_in = '0;
      end else if (s3.hi) begin
         eased_in = $signed(UNIT);
      end else begin
         eased_in = $signed(curve);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         eased_ff <= eased_in;
      end
   end

   assign out_valid = valid_ff;
   assign eased     = eased_ff;

endmodule

`default_nettype wire

/* rtl/easing_curve_evaluator.sv */
//  channel  | ports                          | direction | meaning
//  ---------+--------------------------------+-----------+------------------------------
//  request  | req_valid/req_ready, req_kind, | in        | curve select, progress (8.8)
//           | req_progress                   |           |
//  response | rsp_valid/rsp_ready, rsp_eased | out       | eased progress (2.8, signed)
//
//  One request per cycle sustained while rsp_ready is high; the result shows at rsp_*
//  after four register stages: capture, square, product, finish.
//  Synchronous active-high reset clears only the stage valid bits.
//  A low rsp_ready holds the output register; empty stages still fill behind it,
//  and req_ready drops only once all four stages hold a request.
`timescale 1ns / 1ps
`default_nettype none

module easing_curve_evaluator (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [3:0]         req_kind,
   input  wire logic signed [15:0] req_progress,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [9:0]       rsp_eased
);
   import ecv_pkg::*;

   // stage 1: capture the request and classify the clamp cases
   logic      v1_ff;
   s1_type    s1_ff;
   s1_type    s1_in;

   logic      v2;
   s2_type    s2;
   logic      v3;
   s3_type    s3;
   eased_type eased;

   // per-stage advance: a stage moves when it is empty or the next one moves
   logic      adv1;
   logic      adv2;
   logic      adv3;
   logic      adv4;

   assign adv4 = !rsp_valid || rsp_ready;
   assign adv3 = !v3 || adv4;
   assign adv2 = !v2 || adv3;
   assign adv1 = !v1_ff || adv2;

   assign req_ready = adv1;

   always_comb begin
      s1_in.kind = req_kind;
      s1_in.t    = req_progress[7:0];
      s1_in.lo   = (req_progress <= 16'sd0);
      s1_in.hi   = (req_progress >= 16'sd256);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv1) begin
         v1_ff <= req_valid;
      end
   end

   // hold the payload while stalled
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ff <= s1_in;
      end
   end

   // stage 2: operand select, first square, elastic slope product
   ecv_square u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v1_ff),
      .advance   (adv2),
      .s1        (s1_ff),
      .out_valid (v2),
      .s2        (s2)
   );

   // stage 3: second product (cube / bounce scale), quad and elastic results
   ecv_product u_product (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2),
      .advance   (adv3),
      .s2        (s2),
      .out_valid (v3),
      .s3        (s3)
   );

   // stage 4: finish cubic, back-out and bounce, apply clamps, output register
   ecv_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3),
      .advance   (adv4),
      .s3        (s3),
      .out_valid (rsp_valid),
      .eased     (eased)
   );

   assign rsp_eased = eased;

endmodule

`default_nettype wire

/* rtl/ecv_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ecv_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic signed [9:0] rsp_eased
);

   // response offered but not taken, outside reset
   logic rsp_held;
   assign rsp_held = rsp_valid && !rsp_ready && !reset;

   // reset empties the pipeline
   `ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "response valid after reset")

   // a free output slot means every stage can move
   `ASSERT_CLK(a_ready_free, (!rsp_valid || rsp_ready) |-> req_ready, "request blocked")

   // eased value stays inside the curve range
   `ASSERT_CLK(a_range, rsp_valid |-> rsp_eased >= -10'sd64 && rsp_eased <= 10'sd383, "eased range")

   // a stalled response holds
   `ASSERT_CLK(a_rsp_hold, $past(rsp_held) |-> rsp_valid && $stable(rsp_eased), "response not held")

endmodule

bind easing_curve_evaluator ecv_checker u_ecv_checker (.*);

`default_nettype wire
